[design/varispeed_delay_stop_ramp_top_assert.svh]
// Assertion macros shared by the varispeed delay modules.
// IMP checks a same-cycle implication, NXT checks the following cycle.
`ifndef VARISPEED_DELAY_STOP_RAMP_TOP_ASSERT_SVH
`define VARISPEED_DELAY_STOP_RAMP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define VDSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vdsr: same-cycle check failed");
`define VDSR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vdsr: next-cycle check failed");
`else
`define VDSR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VDSR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/vdsr_pkg.sv]
package vdsr_pkg;

    // Store geometry and sample format
    localparam int STORE_DEPTH = 131072;
    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FILL_W      = $clog2(STORE_DEPTH + 1);

    // Fixed point: Q1.24 speed and progress, Q.24 read delay
    localparam int FRAC_BITS = 24;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int K_W       = Q_W + 1;
    localparam int STEP_W    = 25;
    localparam int DINT_W    = $clog2(STORE_DEPTH / 2 + 1);
    localparam int DELAY_W   = DINT_W + FRAC_BITS;

    // Shared signed multiplier
    localparam int MUL_W  = (SAMPLE_BITS + 2 > K_W + 1) ? SAMPLE_BITS + 2 : K_W + 1;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [Q_W-1:0]     ONE_Q     = Q_W'(1) << FRAC_BITS;
    localparam logic [Q_W-1:0]     HALF_Q    = Q_W'(1) << (FRAC_BITS - 1);
    localparam logic [K_W-1:0]     THREE_Q   = K_W'(3) << FRAC_BITS;
    localparam logic [DELAY_W-1:0] MAX_DELAY = DELAY_W'(STORE_DEPTH / 2) << FRAC_BITS;

    // Configuration registers
    localparam int                  CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_STEP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_START_STEP = CFG_IDX_W'(1);
    localparam logic [STEP_W-1:0]    STEP_RESET     = STEP_W'(699);

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_STOPPING = 2'd1,
        MODE_STOPPED  = 2'd2,
        MODE_STARTING = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REQ_NONE   = 2'd0,
        REQ_STOP   = 2'd1,
        REQ_START  = 2'd2,
        REQ_TOGGLE = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_WRITE,
        OP_SQUARE,
        OP_ROUND,
        OP_CUBE,
        OP_SPEED,
        OP_DELAY,
        OP_ADDR,
        OP_READ0,
        OP_READ1,
        OP_DIFF,
        OP_MUL_L,
        OP_MUL_R,
        OP_FIN
    } t_dp_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SQUARE,
        ST_ROUND,
        ST_CUBE,
        ST_SPEED,
        ST_DELAY,
        ST_ADDR,
        ST_READ0,
        ST_READ1,
        ST_DIFF,
        ST_MUL_L,
        ST_MUL_R,
        ST_FIN
    } t_state;

endpackage

[design/vdsr_if.sv]
interface vdsr_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [vdsr_pkg::SAMPLE_BITS-1:0] sample_left;
    logic signed [vdsr_pkg::SAMPLE_BITS-1:0] sample_right;
    logic [1:0]                             req_type;

    modport source (output valid, output sample_left, output sample_right, output req_type,
                    input ready);
    modport sink   (input valid, input sample_left, input sample_right, input req_type,
                    output ready);
endinterface

interface vdsr_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [vdsr_pkg::SAMPLE_BITS-1:0] out_left;
    logic signed [vdsr_pkg::SAMPLE_BITS-1:0] out_right;
    logic [vdsr_pkg::Q_W-1:0]               speed;
    logic [1:0]                             tape_mode;

    modport source (output valid, output out_left, output out_right, output speed,
                    output tape_mode, input ready);
    modport sink   (input valid, input out_left, input out_right, input speed,
                    input tape_mode, output ready);
endinterface

[design/vdsr_ram.sv]
module vdsr_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/vdsr_dp.sv]
`include "varispeed_delay_stop_ramp_top_assert.svh"

module vdsr_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  vdsr_pkg::t_dp_op                        i_op,
    input  logic                                    i_cfg_we,
    input  logic [vdsr_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [vdsr_pkg::STEP_W-1:0]             i_cfg_data,
    input  logic signed [vdsr_pkg::SAMPLE_BITS-1:0] i_sample_left,
    input  logic signed [vdsr_pkg::SAMPLE_BITS-1:0] i_sample_right,
    input  logic [1:0]                              i_req_type,
    output logic signed [vdsr_pkg::SAMPLE_BITS-1:0] o_out_left,
    output logic signed [vdsr_pkg::SAMPLE_BITS-1:0] o_out_right,
    output logic [vdsr_pkg::Q_W-1:0]                o_speed,
    output logic [1:0]                              o_tape_mode
);

    localparam int SB = vdsr_pkg::SAMPLE_BITS;
    localparam int AW = vdsr_pkg::ADDR_W;
    localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(vdsr_pkg::STORE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(vdsr_pkg::STORE_DEPTH - 1);
    localparam logic [vdsr_pkg::FILL_W-1:0] FILL_FULL =
        vdsr_pkg::FILL_W'(vdsr_pkg::STORE_DEPTH);

    // State that survives between samples
    vdsr_pkg::t_mode                    r_mode, n_mode;
    logic [vdsr_pkg::Q_W-1:0]           r_prog, n_prog;
    logic [vdsr_pkg::DELAY_W-1:0]       r_delay, n_delay;
    logic [AW-1:0]                      r_widx;
    logic [vdsr_pkg::FILL_W-1:0]        r_fill;
    logic [vdsr_pkg::STEP_W-1:0]        r_stop_step, r_start_step;

    // Per-sample working registers
    logic signed [SB-1:0]               r_samp_l, r_samp_r;
    logic signed [vdsr_pkg::PROD_W-1:0] r_prod;
    logic [vdsr_pkg::Q_W-1:0]           r_p2;
    logic [vdsr_pkg::Q_W-1:0]           r_speed;
    logic                               r_clr;
    logic [AW-1:0]                      r_addr0, r_addr1;
    logic [vdsr_pkg::FRAC_BITS-1:0]     r_f;
    logic                               r_v0, r_v1;
    logic signed [SB-1:0]               r_a_l, r_a_r;
    logic signed [SB:0]                 r_diff_l, r_diff_r;
    logic signed [SB-1:0]               r_tmp_l;

    // Result register
    logic signed [SB-1:0]               r_res_l, r_res_r;
    logic [vdsr_pkg::Q_W-1:0]           r_res_speed;
    vdsr_pkg::t_mode                    r_res_mode;

    logic                               mul_en;
    logic signed [vdsr_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic                               ram_we, ram_re;
    logic [AW-1:0]                      ram_raddr;
    logic [2*SB-1:0]                    ram_rdata;

    logic [vdsr_pkg::STEP_W-1:0]        step;
    logic [vdsr_pkg::Q_W:0]             prog_sum;
    logic [vdsr_pkg::K_W-1:0]           k_val;
    logic [vdsr_pkg::PROD_W-1:0]        prod_rnd;
    logic [vdsr_pkg::K_W-1:0]           s_full;
    logic [vdsr_pkg::Q_W-1:0]           s_cap;
    logic [vdsr_pkg::Q_W-1:0]           speed_new;
    logic                               clr_new;
    logic [vdsr_pkg::DELAY_W-1:0]       delay_base;
    logic [vdsr_pkg::DELAY_W:0]         delay_sum;
    logic [vdsr_pkg::FRAC_BITS-1:0]     dfrac;
    logic [vdsr_pkg::DINT_W-1:0]        dint;
    logic [AW:0]                        back;
    logic [AW:0]                        pos;
    logic [AW:0]                        addr0;
    logic [AW-1:0]                      next_addr;
    logic signed [SB-1:0]               rd_l, rd_r;
    logic signed [SB-1:0]               frac_out;

    vdsr_ram #(
        .DEPTH (vdsr_pkg::STORE_DEPTH),
        .WIDTH (2 * SB)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_widx),
        .i_wdata ({r_samp_l, r_samp_r}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_mode    = r_mode;
        n_prog    = r_prog;
        n_delay   = r_delay;
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_addr0;

        // ramp advance, zero step means a full step
        step = (r_mode == vdsr_pkg::MODE_STOPPING) ? r_stop_step : r_start_step;
        if (step == '0) begin
            step = vdsr_pkg::STEP_W'(vdsr_pkg::ONE_Q);
        end
        prog_sum = (vdsr_pkg::Q_W + 1)'(r_prog) + (vdsr_pkg::Q_W + 1)'(step);

        // smoothstep pieces
        k_val    = vdsr_pkg::THREE_Q - {r_prog, 1'b0};
        prod_rnd = $unsigned(r_prod) + vdsr_pkg::PROD_W'(vdsr_pkg::HALF_Q);
        s_full   = prod_rnd[vdsr_pkg::FRAC_BITS +: vdsr_pkg::K_W];
        s_cap    = (s_full > vdsr_pkg::K_W'(vdsr_pkg::ONE_Q)) ? vdsr_pkg::ONE_Q
                                                            : s_full[vdsr_pkg::Q_W-1:0];

        speed_new = vdsr_pkg::ONE_Q;
        clr_new   = 1'b0;
        unique case (r_mode)
            vdsr_pkg::MODE_STOPPING: begin
                speed_new = vdsr_pkg::ONE_Q - s_cap;
                if (r_prog == vdsr_pkg::ONE_Q) begin
                    speed_new = '0;
                end
            end
            vdsr_pkg::MODE_STARTING: begin
                speed_new = s_cap;
                if (r_prog == vdsr_pkg::ONE_Q) begin
                    speed_new = vdsr_pkg::ONE_Q;
                    clr_new   = 1'b1;
                end
            end
            vdsr_pkg::MODE_STOPPED: speed_new = '0;
            vdsr_pkg::MODE_IDLE:    speed_new = vdsr_pkg::ONE_Q;
        endcase

        delay_base = r_clr ? '0 : r_delay;
        delay_sum  = (vdsr_pkg::DELAY_W + 1)'(delay_base)
                   + (vdsr_pkg::DELAY_W + 1)'(vdsr_pkg::ONE_Q - r_speed);

        // read point: newest index minus the delay, split into whole and fraction
        dfrac = r_delay[vdsr_pkg::FRAC_BITS-1:0];
        dint  = r_delay[vdsr_pkg::FRAC_BITS +: vdsr_pkg::DINT_W];
        back  = (AW + 1)'(dint) + (AW + 1)'(dfrac != '0);
        pos   = (AW + 1)'(r_widx) + DEPTH_X - back;
        addr0 = (pos >= DEPTH_X) ? pos - DEPTH_X : pos;
        next_addr = (r_addr0 == LAST_ADDR) ? '0 : r_addr0 + 1'b1;

        rd_l     = ram_rdata[2*SB-1:SB];
        rd_r     = ram_rdata[SB-1:0];
        frac_out = prod_rnd[vdsr_pkg::FRAC_BITS +: SB];

        unique case (i_op)
            vdsr_pkg::OP_LOAD: begin
                unique case (vdsr_pkg::t_req'(i_req_type))
                    vdsr_pkg::REQ_NONE: begin
                    end
                    vdsr_pkg::REQ_STOP: begin
                        if (r_mode == vdsr_pkg::MODE_IDLE) begin
                            n_mode = vdsr_pkg::MODE_STOPPING;
                            n_prog = '0;
                        end
                    end
                    vdsr_pkg::REQ_START: begin
                        if (r_mode == vdsr_pkg::MODE_STOPPED) begin
                            n_mode = vdsr_pkg::MODE_STARTING;
                            n_prog = '0;
                        end
                    end
                    vdsr_pkg::REQ_TOGGLE: begin
                        if (r_mode == vdsr_pkg::MODE_IDLE ||
                            r_mode == vdsr_pkg::MODE_STARTING) begin
                            n_mode = vdsr_pkg::MODE_STOPPING;
                        end else begin
                            n_mode = vdsr_pkg::MODE_STARTING;
                        end
                        n_prog = '0;
                    end
                endcase
            end
            vdsr_pkg::OP_WRITE: begin
                ram_we = 1'b1;
                if (r_mode == vdsr_pkg::MODE_STOPPING ||
                    r_mode == vdsr_pkg::MODE_STARTING) begin
                    n_prog = (prog_sum >= (vdsr_pkg::Q_W + 1)'(vdsr_pkg::ONE_Q))
                           ? vdsr_pkg::ONE_Q : prog_sum[vdsr_pkg::Q_W-1:0];
                end
            end
            vdsr_pkg::OP_SQUARE: begin
                mul_en = 1'b1;
                mul_a  = $signed(vdsr_pkg::MUL_W'(r_prog));
                mul_b  = $signed(vdsr_pkg::MUL_W'(r_prog));
            end
            vdsr_pkg::OP_CUBE: begin
                mul_en = 1'b1;
                mul_a  = $signed(vdsr_pkg::MUL_W'(r_p2));
                mul_b  = $signed(vdsr_pkg::MUL_W'(k_val));
            end
            vdsr_pkg::OP_SPEED: begin
                if (r_prog == vdsr_pkg::ONE_Q) begin
                    if (r_mode == vdsr_pkg::MODE_STOPPING) begin
                        n_mode = vdsr_pkg::MODE_STOPPED;
                    end else if (r_mode == vdsr_pkg::MODE_STARTING) begin
                        n_mode = vdsr_pkg::MODE_IDLE;
                    end
                end
            end
            vdsr_pkg::OP_DELAY: begin
                n_delay = (delay_sum > (vdsr_pkg::DELAY_W + 1)'(vdsr_pkg::MAX_DELAY))
                        ? vdsr_pkg::MAX_DELAY : delay_sum[vdsr_pkg::DELAY_W-1:0];
            end
            vdsr_pkg::OP_READ0: begin
                ram_re    = 1'b1;
                ram_raddr = r_addr0;
            end
            vdsr_pkg::OP_READ1: begin
                ram_re    = 1'b1;
                ram_raddr = r_addr1;
            end
            vdsr_pkg::OP_MUL_L: begin
                mul_en = 1'b1;
                mul_a  = vdsr_pkg::MUL_W'(r_diff_l);
                mul_b  = $signed(vdsr_pkg::MUL_W'(r_f));
            end
            vdsr_pkg::OP_MUL_R: begin
                mul_en = 1'b1;
                mul_a  = vdsr_pkg::MUL_W'(r_diff_r);
                mul_b  = $signed(vdsr_pkg::MUL_W'(r_f));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= vdsr_pkg::MODE_IDLE;
            r_prog       <= '0;
            r_delay      <= '0;
            r_widx       <= '0;
            r_fill       <= '0;
            r_stop_step  <= vdsr_pkg::STEP_RESET;
            r_start_step <= vdsr_pkg::STEP_RESET;
        end else begin
            r_mode  <= n_mode;
            r_prog  <= n_prog;
            r_delay <= n_delay;
            if (i_op == vdsr_pkg::OP_WRITE && r_fill != FILL_FULL) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_op == vdsr_pkg::OP_FIN) begin
                r_widx <= (r_widx == LAST_ADDR) ? '0 : r_widx + 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    vdsr_pkg::CFG_STOP_STEP:  r_stop_step  <= i_cfg_data;
                    vdsr_pkg::CFG_START_STEP: r_start_step <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        unique case (i_op)
            vdsr_pkg::OP_LOAD: begin
                r_samp_l <= i_sample_left;
                r_samp_r <= i_sample_right;
            end
            vdsr_pkg::OP_ROUND: r_p2 <= prod_rnd[vdsr_pkg::FRAC_BITS +: vdsr_pkg::Q_W];
            vdsr_pkg::OP_SPEED: begin
                r_speed <= speed_new;
                r_clr   <= clr_new;
            end
            vdsr_pkg::OP_ADDR: begin
                r_addr0 <= addr0[AW-1:0];
                // weight of the newer sample: one minus the fraction, zero when whole
                r_f     <= '0 - dfrac;
            end
            vdsr_pkg::OP_READ0: begin
                r_v0    <= (vdsr_pkg::FILL_W'(r_addr0) < r_fill);
                r_addr1 <= next_addr;
            end
            vdsr_pkg::OP_READ1: begin
                // entries never written since reset read as zero
                r_a_l <= r_v0 ? rd_l : '0;
                r_a_r <= r_v0 ? rd_r : '0;
                r_v1  <= (vdsr_pkg::FILL_W'(r_addr1) < r_fill);
            end
            vdsr_pkg::OP_DIFF: begin
                r_diff_l <= (r_v1 ? (SB + 1)'(rd_l) : '0) - (SB + 1)'(r_a_l);
                r_diff_r <= (r_v1 ? (SB + 1)'(rd_r) : '0) - (SB + 1)'(r_a_r);
            end
            vdsr_pkg::OP_MUL_R: r_tmp_l <= r_a_l + frac_out;
            vdsr_pkg::OP_FIN: begin
                r_res_l     <= r_tmp_l;
                r_res_r     <= r_a_r + frac_out;
                r_res_speed <= r_speed;
                r_res_mode  <= r_mode;
            end
            default: begin
            end
        endcase
    end

    assign o_out_left  = r_res_l;
    assign o_out_right = r_res_r;
    assign o_speed     = r_res_speed;
    assign o_tape_mode = r_res_mode;

    `VDSR_ASSERT_IMP(a_prog_cap, i_clk, i_rst_n, 1'b1, r_prog <= vdsr_pkg::ONE_Q)
    `VDSR_ASSERT_IMP(a_delay_cap, i_clk, i_rst_n, 1'b1, r_delay <= vdsr_pkg::MAX_DELAY)
    `VDSR_ASSERT_NXT(a_stopped_still, i_clk, i_rst_n, i_op == vdsr_pkg::OP_SPEED, r_mode != vdsr_pkg::MODE_STOPPED || r_speed == '0)

endmodule

[design/vdsr_ctrl.sv]
`include "varispeed_delay_stop_ramp_top_assert.svh"

module vdsr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output vdsr_pkg::t_dp_op o_op
);

    vdsr_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vdsr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = vdsr_pkg::OP_NONE;
        o_in_ready = 1'b0;
        n_out_valid = (r_out_valid && !i_out_ready);
        unique case (r_state)
            vdsr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = vdsr_pkg::OP_LOAD;
                    n_state = vdsr_pkg::ST_WRITE;
                end
            end
            vdsr_pkg::ST_WRITE: begin
                o_op    = vdsr_pkg::OP_WRITE;
                n_state = vdsr_pkg::ST_SQUARE;
            end
            vdsr_pkg::ST_SQUARE: begin
                o_op    = vdsr_pkg::OP_SQUARE;
                n_state = vdsr_pkg::ST_ROUND;
            end
            vdsr_pkg::ST_ROUND: begin
                o_op    = vdsr_pkg::OP_ROUND;
                n_state = vdsr_pkg::ST_CUBE;
            end
            vdsr_pkg::ST_CUBE: begin
                o_op    = vdsr_pkg::OP_CUBE;
                n_state = vdsr_pkg::ST_SPEED;
            end
            vdsr_pkg::ST_SPEED: begin
                o_op    = vdsr_pkg::OP_SPEED;
                n_state = vdsr_pkg::ST_DELAY;
            end
            vdsr_pkg::ST_DELAY: begin
                o_op    = vdsr_pkg::OP_DELAY;
                n_state = vdsr_pkg::ST_ADDR;
            end
            vdsr_pkg::ST_ADDR: begin
                o_op    = vdsr_pkg::OP_ADDR;
                n_state = vdsr_pkg::ST_READ0;
            end
            vdsr_pkg::ST_READ0: begin
                o_op    = vdsr_pkg::OP_READ0;
                n_state = vdsr_pkg::ST_READ1;
            end
            vdsr_pkg::ST_READ1: begin
                o_op    = vdsr_pkg::OP_READ1;
                n_state = vdsr_pkg::ST_DIFF;
            end
            vdsr_pkg::ST_DIFF: begin
                o_op    = vdsr_pkg::OP_DIFF;
                n_state = vdsr_pkg::ST_MUL_L;
            end
            vdsr_pkg::ST_MUL_L: begin
                o_op    = vdsr_pkg::OP_MUL_L;
                n_state = vdsr_pkg::ST_MUL_R;
            end
            vdsr_pkg::ST_MUL_R: begin
                o_op    = vdsr_pkg::OP_MUL_R;
                n_state = vdsr_pkg::ST_FIN;
            end
            vdsr_pkg::ST_FIN: begin
                // hold until the result register is free or drains this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_op        = vdsr_pkg::OP_FIN;
                    n_out_valid = 1'b1;
                    n_state     = vdsr_pkg::ST_IDLE;
                end
            end
            default: n_state = vdsr_pkg::ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

    `VDSR_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `VDSR_ASSERT_IMP(a_fin_slot, i_clk, i_rst_n, o_op == vdsr_pkg::OP_FIN, !r_out_valid || i_out_ready)

endmodule

[design/varispeed_delay_stop_ramp_top.sv]
// A new request is accepted only after the previous one has finished; the
// controller sequence, set around the shared multiplier (four products) and
// the single store read port, holds at finish while the output is stalled.
// Reset: synchronous active low; clears mode, ramp progress, read delay, write
// index and fill count, and loads both step registers with 699. The sample
// store is not swept; a fill count makes unwritten entries read as zero.
module varispeed_delay_stop_ramp_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vdsr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vdsr_pkg::STEP_W-1:0]    i_cfg_data,
    vdsr_in_if.sink                        i_in,
    vdsr_out_if.source                     o_out
);

    // The controller walks each request through a fixed sequence:
    //   accept  - capture the stereo pair, apply the stop/start/toggle command
    //   write   - store the pair at the write index, advance the ramp progress
    //   square  - progress squared on the shared multiplier
    //   round   - round the square to Q.24
    //   cube    - square times (3 - 2p)
    //   speed   - cap the smoothstep, pick speed by mode, end a finished ramp
    //   delay   - add (1 - speed), zeroed when a start ends, clamp at half the store
    //   address - split the delay, form the older read index and the weight
    //   read0/1 - fetch the two neighboring stored pairs
    //   diff    - newer minus older sample per channel
    //   mul L/R - difference times weight, round and add to the older sample
    //   finish  - load the result register, advance the write index
    // The result register lets the next request enter while a result waits.

    vdsr_pkg::t_dp_op op;

    vdsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_op        (op)
    );

    vdsr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_left  (i_in.sample_left),
        .i_sample_right (i_in.sample_right),
        .i_req_type     (i_in.req_type),
        .o_out_left     (o_out.out_left),
        .o_out_right    (o_out.out_right),
        .o_speed        (o_out.speed),
        .o_tape_mode    (o_out.tape_mode)
    );

endmodule
